FILE: sv/sclt_pkg.sv
// package: word types, token kinds, held codes and result bundle for the tokenizer
package sclt_pkg;

    // token kinds carried in the result word
    localparam logic [2:0] K_BYTE  = 3'd0;
    localparam logic [2:0] K_WEND  = 3'd1;
    localparam logic [2:0] K_PIPE  = 3'd2;
    localparam logic [2:0] K_GT    = 3'd3;
    localparam logic [2:0] K_GTGT  = 3'd4;
    localparam logic [2:0] K_2GT   = 3'd5;
    localparam logic [2:0] K_2GTGT = 3'd6;
    localparam logic [2:0] K_LEND  = 3'd7;

    // held digit codes
    localparam logic [1:0] HD_NONE = 2'd0;
    localparam logic [1:0] HD_ONE  = 2'd1;
    localparam logic [1:0] HD_TWO  = 2'd2;

    // held redirect codes
    localparam logic [2:0] HR_NONE = 3'd0;
    localparam logic [2:0] HR_GT   = 3'd1;
    localparam logic [2:0] HR_1GT  = 3'd2;
    localparam logic [2:0] HR_2GT  = 3'd3;

    // special bytes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // results per input word and queue sizing
    localparam int MAX_RES = 4;
    localparam int RIDX_W  = $clog2(MAX_RES);
    localparam int RCNT_W  = $clog2(MAX_RES + 1);
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] char_byte;
        logic       no_char;
        logic       end_of_line;
    } in_word_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] word_byte;
        logic       stream_one;
        logic       last;
    } out_word_t;

    // all results caused by one input word
    typedef struct packed {
        logic [RCNT_W-1:0]           cnt;
        out_word_t [MAX_RES-1:0]     res;
    } bundle_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic    valid;
        bundle_t data;
    } q_head_t;

    // append one result, results past the limit are dropped
    function automatic bundle_t add_res(bundle_t b, logic [2:0] kind, logic [7:0] byte_v,
                                        logic s1);
        out_word_t w;
        w.kind       = kind;
        w.word_byte  = (kind == K_BYTE) ? byte_v : 8'h00;
        w.stream_one = s1;
        w.last       = 1'b0;
        if (b.cnt < RCNT_W'(MAX_RES)) begin
            b.res[b.cnt[RIDX_W-1:0]] = w;
            b.cnt = b.cnt + RCNT_W'(1);
        end
        return b;
    endfunction

    // append a redirect token from a held code
    function automatic bundle_t add_redir(bundle_t b, logic [2:0] code, logic dbl);
        bundle_t r;
        if (code == HR_GT) begin
            r = add_res(b, dbl ? K_GTGT : K_GT, 8'h00, 1'b0);
        end else if (code == HR_1GT) begin
            r = add_res(b, dbl ? K_GTGT : K_GT, 8'h00, 1'b1);
        end else begin
            r = add_res(b, dbl ? K_2GTGT : K_2GT, 8'h00, 1'b0);
        end
        return r;
    endfunction

endpackage

FILE: sv/sclt_front.sv
// front end: takes input words, tracks quoting state and builds result bundles
module sclt_front import sclt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_word_t s_data,
    input  logic     q_full,
    output logic     q_push,
    output bundle_t  q_bundle
);

    logic       sq_reg, sq_next;
    logic       dq_reg, dq_next;
    logic       esc_reg, esc_next;
    logic       wopen_reg, wopen_next;
    logic [1:0] hd_reg, hd_next;
    logic [2:0] hr_reg, hr_next;
    bundle_t    bnd;
    logic       accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // classify the byte and collect its results
    always_comb begin
        logic [7:0] c;
        logic       eol;
        logic       do_plain;
        logic [2:0] code;
        logic       blank;
        c        = s_data.char_byte;
        eol      = s_data.no_char || s_data.end_of_line;
        do_plain = 1'b0;
        code     = HR_NONE;
        blank    = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
        sq_next    = sq_reg;
        dq_next    = dq_reg;
        esc_next   = esc_reg;
        wopen_next = wopen_reg;
        hd_next    = hd_reg;
        hr_next    = hr_reg;
        bnd        = '0;

        // resolve held redirect or digit against the raw byte
        if (!s_data.no_char) begin
            if (hr_next != HR_NONE) begin
                code    = hr_next;
                hr_next = HR_NONE;
                if (c == CH_GT) begin
                    bnd = add_redir(bnd, code, 1'b1);
                end else begin
                    bnd      = add_redir(bnd, code, 1'b0);
                    do_plain = 1'b1;
                end
            end else if (hd_next != HD_NONE) begin
                if (c == CH_GT) begin
                    hr_next = (hd_next == HD_ONE) ? HR_1GT : HR_2GT;
                end else begin
                    bnd        = add_res(bnd, K_BYTE,
                                         (hd_next == HD_ONE) ? CH_ONE : CH_TWO, 1'b0);
                    wopen_next = 1'b1;
                    do_plain   = 1'b1;
                end
                hd_next = HD_NONE;
            end else begin
                do_plain = 1'b1;
            end
        end

        // ordinary byte handling
        if (do_plain) begin
            if (esc_next) begin
                if (dq_next && c != CH_BSLASH && c != CH_DQUOTE) begin
                    bnd = add_res(bnd, K_BYTE, CH_BSLASH, 1'b0);
                end
                bnd        = add_res(bnd, K_BYTE, c, 1'b0);
                wopen_next = 1'b1;
                esc_next   = 1'b0;
            end else if (c == CH_BSLASH && !sq_next) begin
                esc_next = 1'b1;
            end else if (c == CH_SQUOTE && !dq_next) begin
                sq_next = !sq_next;
            end else if (c == CH_DQUOTE && !sq_next) begin
                dq_next = !dq_next;
            end else if (!sq_next && !dq_next && blank) begin
                if (wopen_next) begin
                    bnd = add_res(bnd, K_WEND, 8'h00, 1'b0);
                end
                wopen_next = 1'b0;
            end else if (!sq_next && !dq_next && c == CH_PIPE) begin
                if (wopen_next) begin
                    bnd = add_res(bnd, K_WEND, 8'h00, 1'b0);
                end
                wopen_next = 1'b0;
                bnd        = add_res(bnd, K_PIPE, 8'h00, 1'b0);
            end else if (!sq_next && !dq_next && (c == CH_ONE || c == CH_TWO) && !wopen_next) begin
                hd_next = (c == CH_ONE) ? HD_ONE : HD_TWO;
            end else if (!sq_next && !dq_next && c == CH_GT) begin
                if (wopen_next) begin
                    bnd = add_res(bnd, K_WEND, 8'h00, 1'b0);
                end
                wopen_next = 1'b0;
                hr_next    = HR_GT;
            end else begin
                bnd        = add_res(bnd, K_BYTE, c, 1'b0);
                wopen_next = 1'b1;
            end
        end

        // line end flush
        if (eol) begin
            if (hr_next != HR_NONE) begin
                bnd = add_redir(bnd, hr_next, 1'b0);
            end
            if (hd_next != HD_NONE) begin
                bnd        = add_res(bnd, K_BYTE,
                                     (hd_next == HD_ONE) ? CH_ONE : CH_TWO, 1'b0);
                wopen_next = 1'b1;
            end
            if (wopen_next) begin
                bnd = add_res(bnd, K_WEND, 8'h00, 1'b0);
            end
            bnd        = add_res(bnd, K_LEND, 8'h00, 1'b0);
            sq_next    = 1'b0;
            dq_next    = 1'b0;
            esc_next   = 1'b0;
            wopen_next = 1'b0;
            hd_next    = HD_NONE;
            hr_next    = HR_NONE;
        end

        // mark the final result of this word
        if (bnd.cnt != '0) begin
            bnd.res[RIDX_W'(bnd.cnt - RCNT_W'(1))].last = 1'b1;
        end
    end

    assign q_push   = accept && (bnd.cnt != '0);
    assign q_bundle = bnd;

    // tokenizer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_reg    <= 1'b0;
            dq_reg    <= 1'b0;
            esc_reg   <= 1'b0;
            wopen_reg <= 1'b0;
            hd_reg    <= HD_NONE;
            hr_reg    <= HR_NONE;
        end else if (accept) begin
            sq_reg    <= sq_next;
            dq_reg    <= dq_next;
            esc_reg   <= esc_next;
            wopen_reg <= wopen_next;
            hd_reg    <= hd_next;
            hr_reg    <= hr_next;
        end
    end

endmodule

FILE: sv/sclt_queue.sv
// short queue of result bundles between front and back
module sclt_queue import sclt_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    input  logic    pop,
    output q_head_t head
);

    bundle_t           mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_pop;

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.data  = mem[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !do_pop) begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end else if (!push && do_pop) begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

endmodule

FILE: sv/sclt_back.sv
// back end: walks each bundle and sends one result word per cycle while m_ready is high
module sclt_back import sclt_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  q_head_t   head,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic [RIDX_W-1:0] sub_reg;
    logic              out_valid_reg;
    out_word_t         out_data_reg;
    logic              load;
    logic              at_end;

    assign load    = head.valid && (!out_valid_reg || m_ready);
    assign at_end  = (RCNT_W'(sub_reg) + RCNT_W'(1)) >= head.data.cnt;
    assign pop     = load && at_end;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // result index within the current bundle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                sub_reg <= at_end ? '0 : sub_reg + RIDX_W'(1);
            end
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg <= head.data.res[sub_reg];
        end
    end

endmodule

FILE: sv/shell_command_line_tokenizer.sv
// top level of the shell command line tokenizer
//
//  channel | dir | payload    | handshake
//  s_      | in  | in_word_t  | s_valid / s_ready
//  m_      | out | out_word_t | m_valid / m_ready
//
// one input byte per cycle while the bundle queue has room
// each byte gives zero to four result words, sent one per cycle while m_ready is high from an output register
// sustained rate is set by the back end, which serializes the result words; four bundles buffered
// reset is synchronous and active low, clears tokenizer state, queue and output valid
// a stall on m_ready fills the queue, then s_ready drops until a bundle drains
module shell_command_line_tokenizer import sclt_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic    q_full;
    logic    q_push;
    logic    q_pop;
    bundle_t q_bundle;
    q_head_t q_head;

    // classify input bytes
    sclt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_bundle (q_bundle)
    );

    // decouple front and back
    sclt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_bundle),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head)
    );

    // serialize result words
    sclt_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (q_head),
        .pop     (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: sv/sclt_checker.sv
// port checker for the tokenizer and its bind
module sclt_checker import sclt_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // no output in the cycle after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // byte field only carries data for word bytes
    a_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind != K_BYTE |-> m_data.word_byte == 8'h00)
        else $error("word_byte set on a non-byte token");

    // stream flag only on single-stream redirects
    a_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.stream_one |-> (m_data.kind == K_GT || m_data.kind == K_GTGT))
        else $error("stream_one on wrong token kind");

    // line end always closes the results of its input word
    a_lend: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == K_LEND |-> m_data.last)
        else $error("line end without last");

endmodule

bind shell_command_line_tokenizer sclt_checker u_sclt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: dv/tb.sv
// testbench for the shell command line tokenizer: directed and random lines against a predictor
`timescale 1ns / 1ps

module tb;
    import sclt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    shell_command_line_tokenizer DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // tokens still owed by the block, oldest first
    out_word_t token_expect[$];
    int        err_n   = 0;
    int        sent_n  = 0;
    int        cyc_n   = 0;
    logic      idle_on = 1'b1;

    // predictor state
    logic       sq_st;
    logic       dq_st;
    logic       esc_st;
    logic       word_st;
    logic [1:0] hold_dig;
    logic [2:0] hold_redir;
    out_word_t  tok_buf[MAX_RES];
    int         tok_n;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cyc_n <= cyc_n + 1;
        if (cyc_n == CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic void clear_tokenizer();
        sq_st      = 1'b0;
        dq_st      = 1'b0;
        esc_st     = 1'b0;
        word_st    = 1'b0;
        hold_dig   = HD_NONE;
        hold_redir = HR_NONE;
    endfunction

    function automatic void put_tok(logic [2:0] k, logic [7:0] b, logic s1);
        out_word_t t;
        t.kind       = k;
        t.word_byte  = (k == K_BYTE) ? b : 8'h00;
        t.stream_one = s1;
        t.last       = 1'b0;
        if (tok_n < MAX_RES) begin
            tok_buf[tok_n] = t;
            tok_n++;
        end
    endfunction

    function automatic void put_char(logic [7:0] b);
        put_tok(K_BYTE, b, 1'b0);
        word_st = 1'b1;
    endfunction

    function automatic void close_word();
        if (word_st) begin
            put_tok(K_WEND, 8'h00, 1'b0);
            word_st = 1'b0;
        end
    endfunction

    function automatic void put_redir(logic [2:0] code, logic dbl);
        if (code == HR_GT) begin
            put_tok(dbl ? K_GTGT : K_GT, 8'h00, 1'b0);
        end else if (code == HR_1GT) begin
            put_tok(dbl ? K_GTGT : K_GT, 8'h00, 1'b1);
        end else begin
            put_tok(dbl ? K_2GTGT : K_2GT, 8'h00, 1'b0);
        end
    endfunction

    // one raw byte with nothing held in front of it
    function automatic void scan_byte(logic [7:0] c);
        if (esc_st) begin
            if (dq_st && c != CH_BSLASH && c != CH_DQUOTE) put_char(CH_BSLASH);
            put_char(c);
            esc_st = 1'b0;
            return;
        end
        if (c == CH_BSLASH && !sq_st) begin
            esc_st = 1'b1;
            return;
        end
        if (c == CH_SQUOTE && !dq_st) begin
            sq_st = ~sq_st;
            return;
        end
        if (c == CH_DQUOTE && !sq_st) begin
            dq_st = ~dq_st;
            return;
        end
        if (!sq_st && !dq_st) begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                close_word();
                return;
            end
            if (c == CH_PIPE) begin
                close_word();
                put_tok(K_PIPE, 8'h00, 1'b0);
                return;
            end
            if ((c == CH_ONE || c == CH_TWO) && !word_st) begin
                hold_dig = (c == CH_ONE) ? HD_ONE : HD_TWO;
                return;
            end
            if (c == CH_GT) begin
                close_word();
                hold_redir = HR_GT;
                return;
            end
        end
        put_char(c);
    endfunction

    // work out the tokens of one accepted input word and queue them
    function automatic void tokenize_word(in_word_t w);
        logic [2:0] code;
        logic [1:0] d;
        logic       eol;
        eol   = w.no_char | w.end_of_line;
        tok_n = 0;
        if (!w.no_char) begin
            if (hold_redir != HR_NONE) begin
                code       = hold_redir;
                hold_redir = HR_NONE;
                if (w.char_byte == CH_GT) begin
                    put_redir(code, 1'b1);
                end else begin
                    put_redir(code, 1'b0);
                    scan_byte(w.char_byte);
                end
            end else if (hold_dig != HD_NONE) begin
                d        = hold_dig;
                hold_dig = HD_NONE;
                if (w.char_byte == CH_GT) begin
                    hold_redir = (d == HD_ONE) ? HR_1GT : HR_2GT;
                end else begin
                    put_char((d == HD_ONE) ? CH_ONE : CH_TWO);
                    scan_byte(w.char_byte);
                end
            end else begin
                scan_byte(w.char_byte);
            end
        end
        // line end flushes whatever is held
        if (eol) begin
            if (hold_redir != HR_NONE) put_redir(hold_redir, 1'b0);
            if (hold_dig != HD_NONE) put_char((hold_dig == HD_ONE) ? CH_ONE : CH_TWO);
            close_word();
            put_tok(K_LEND, 8'h00, 1'b0);
            clear_tokenizer();
        end
        if (tok_n > 0) tok_buf[tok_n-1].last = 1'b1;
        for (int i = 0; i < tok_n; i++) token_expect.insert(token_expect.size(), tok_buf[i]);
    endfunction

    // ---------------- checking ----------------

    task automatic flag_mismatch(string msg);
        err_n++;
        if (err_n <= 40) $display("mismatch at cycle %0d: %s", cyc_n, msg);
    endtask

    // result side stalls
    always @(posedge aclk) begin
        m_ready <= idle_on ? ($urandom_range(0, 99) >= 10) : 1'b1;
    end

    // compare each accepted result word with the oldest expectation
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (token_expect.size() == 0) begin
                flag_mismatch($sformatf("unexpected word kind %0d", m_data.kind));
            end else begin
                want = token_expect.pop_front();
                if (m_data.kind != want.kind)
                    flag_mismatch($sformatf("kind got %0d exp %0d", m_data.kind, want.kind));
                if (m_data.word_byte != want.word_byte)
                    flag_mismatch($sformatf("word_byte got %02h exp %02h",
                                            m_data.word_byte, want.word_byte));
                if (m_data.stream_one != want.stream_one)
                    flag_mismatch($sformatf("stream_one got %0b exp %0b",
                                            m_data.stream_one, want.stream_one));
                if (m_data.last != want.last)
                    flag_mismatch($sformatf("last got %0b exp %0b", m_data.last, want.last));
            end
        end
    end

    // ---------------- stimulus ----------------

    // send one word on the input channel, predict once it is taken
    task automatic send_word(logic [7:0] c, logic nc, logic eol);
        in_word_t w;
        w.char_byte   = c;
        w.no_char     = nc;
        w.end_of_line = eol;
        if (idle_on && $urandom_range(0, 99) < 10) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        tokenize_word(w);
        sent_n++;
    endtask

    // command line bytes, weighted toward the ones the tokenizer cares about
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 28) return 8'h61 + 8'($urandom_range(0, 25));
        if (r < 38) return ($urandom_range(0, 1) != 0) ? CH_ONE : CH_TWO;
        if (r < 50) return CH_GT;
        if (r < 55) return CH_PIPE;
        if (r < 63) return (r < 58) ? CH_SPACE : 8'(8'h09 + $urandom_range(0, 4));
        if (r < 68) return CH_DQUOTE;
        if (r < 72) return CH_SQUOTE;
        if (r < 79) return CH_BSLASH;
        return 8'($urandom_range(0, 255));
    endfunction

    // extremes of the fields and each special case
    task automatic test_directed();
        send_word("x", 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(CH_TAB, 1'b0, 1'b0);
        // 1> then >> form
        send_word(CH_ONE, 1'b0, 1'b0);
        send_word(CH_GT, 1'b0, 1'b0);
        send_word(CH_GT, 1'b0, 1'b0);
        // 2> followed by another byte
        send_word(CH_TWO, 1'b0, 1'b0);
        send_word(CH_GT, 1'b0, 1'b0);
        send_word("q", 1'b0, 1'b0);
        send_word(CH_PIPE, 1'b0, 1'b0);
        // held > then a quote
        send_word(CH_GT, 1'b0, 1'b0);
        send_word(CH_DQUOTE, 1'b0, 1'b0);
        // escapes inside double quotes
        send_word(CH_BSLASH, 1'b0, 1'b0);
        send_word("n", 1'b0, 1'b0);
        send_word(CH_BSLASH, 1'b0, 1'b0);
        send_word(CH_DQUOTE, 1'b0, 1'b0);
        send_word(CH_DQUOTE, 1'b0, 1'b0);
        // backslash is literal inside single quotes
        send_word(CH_SQUOTE, 1'b0, 1'b0);
        send_word(CH_BSLASH, 1'b0, 1'b0);
        send_word(CH_SQUOTE, 1'b0, 1'b0);
        // pending escape dropped at line end
        send_word(CH_BSLASH, 1'b0, 1'b1);
        // empty line, byte ignored, line end flag low
        send_word(8'hFF, 1'b1, 1'b0);
        // held digit and held redirect flushed at line end
        send_word(CH_TWO, 1'b0, 1'b1);
        send_word(CH_GT, 1'b0, 1'b1);
        // open quote ignored at line end
        send_word(CH_DQUOTE, 1'b0, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
    endtask

    // mostly well formed lines, some noise
    task automatic test_random_lines(int count, logic with_idle);
        int len;
        int stop_at;
        idle_on = with_idle;
        stop_at = sent_n + count;
        while (sent_n < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) == 0),
                          1'($urandom_range(0, 1)));
            end else begin
                len = $urandom_range(0, 10);
                if (len == 0 || $urandom_range(0, 4) == 0) begin
                    for (int i = 0; i < len; i++) send_word(pick_char(), 1'b0, 1'b0);
                    send_word(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
                end else begin
                    for (int i = 0; i < len; i++)
                        send_word(pick_char(), 1'b0, 1'(i == len - 1));
                end
            end
        end
    endtask

    initial begin
        clear_tokenizer();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_lines(180, 1'b1);
        test_random_lines(110, 1'b0);
        idle_on = 1'b1;
        s_valid <= 1'b0;
        // drain, then let the output register settle
        while (token_expect.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (err_n == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/sclt_pkg.sv
sv/sclt_front.sv
sv/sclt_queue.sv
sv/sclt_back.sv
sv/shell_command_line_tokenizer.sv
sv/sclt_checker.sv
dv/tb.sv
